[src/command_frame_parser_relay_schedule_unit_macros.svh]
// Assertion macros for the command frame parser and relay schedule unit.
// Used by files that include it; they must provide i_clk and i_rst_n.
`ifndef COMMAND_FRAME_PARSER_RELAY_SCHEDULE_UNIT_MACROS_SVH
`define COMMAND_FRAME_PARSER_RELAY_SCHEDULE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CFRS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CFRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/cfrs_pkg.sv]
// Package for the command frame parser and relay schedule unit.
// Holds character codes, reset values, the decoded command type and digit helpers.
`timescale 1ns / 1ps

package cfrs_pkg;

    // Frame window: ten bytes, the newest one is the incoming character itself.
    localparam int WINDOW_LEN = 10;
    localparam int HIST_LEN   = WINDOW_LEN - 1;
    localparam int MAX_RELAYS = 8;
    localparam int MASK_W     = 3;
    localparam int MODE_MAX   = 6;

    // Framing characters.
    localparam logic [7:0] CH_X      = 8'h58;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;

    // Command letters.
    localparam logic [7:0] CMD_T = 8'h54;
    localparam logic [7:0] CMD_I = 8'h49;
    localparam logic [7:0] CMD_N = 8'h4E;
    localparam logic [7:0] CMD_F = 8'h46;
    localparam logic [7:0] CMD_B = 8'h42;
    localparam logic [7:0] CMD_C = 8'h43;
    localparam logic [7:0] CMD_D = 8'h44;
    localparam logic [7:0] CMD_E = 8'h45;
    localparam logic [7:0] CMD_G = 8'h47;
    localparam logic [7:0] CMD_H = 8'h48;
    localparam logic [7:0] CMD_J = 8'h4A;
    localparam logic [7:0] CMD_K = 8'h4B;
    localparam logic [7:0] CMD_L = 8'h4C;
    localparam logic [7:0] CMD_M = 8'h4D;
    localparam logic [7:0] CMD_O = 8'h4F;
    localparam logic [7:0] CMD_U = 8'h55;
    localparam logic [7:0] CMD_A = 8'h41;

    // Reset values; times are kept as hours*100+minutes.
    localparam logic [11:0] RST_ON_TIME  = 12'd2210;
    localparam logic [11:0] RST_OFF_TIME = 12'd501;
    localparam logic [29:0] RST_PULSE_MS = 30'd5000;
    localparam logic [15:0] RST_UPPER    = 16'd2200;
    localparam logic [15:0] RST_LOWER    = 16'd800;

    // Settings update that a completed frame asks for.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLOCK,
        OP_ON_TIME,
        OP_OFF_TIME,
        OP_PULSE,
        OP_MODE,
        OP_UPPER,
        OP_LOWER,
        OP_SENSOR
    } t_op;

    typedef struct packed {
        logic                  found;
        t_op                   op;
        logic                  all_relays;
        logic [1:0]            relay;
        logic [11:0]           hhmm;
        logic [29:0]           ms;
        logic [MAX_RELAYS-1:0] mode_bits;
        logic [15:0]           limit;
        logic                  sensor_on;
        logic [4:0]            hours;
        logic [5:0]            minutes;
        logic [5:0]            seconds;
    } t_frame_cmd;

    // Decimal digit test.
    function automatic logic is_dec(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // Hex digit value, or 16 when the character is not a hex digit.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            v = {1'b0, c[3:0]};
        end else if (((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66))) begin
            v = {1'b0, c[3:0]} + 5'd9;
        end else begin
            v = 5'd16;
        end
        return v;
    endfunction

endpackage

[src/command_frame_parser_relay_schedule_unit.sv]
// Top level of the command frame parser and relay schedule unit.
// Depends on cfrs_pkg, cfrs_frame and the assertion macro header.
`timescale 1ns / 1ps

// Every item, a received character or a schedule query, returns exactly one result
// that shows the settings as they stand after the item. An item is registered in
// the input register, where the frame decoder, the settings update and the schedule
// compare run as one combinational pass, and is then held in the result register;
// one item is taken every cycle while the result side keeps up. A frame is 'X', a
// command letter, six parameters, '$' and newline.
module command_frame_parser_relay_schedule_unit import cfrs_pkg::*; #(
    parameter int RELAY_COUNT = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_char_byte,
    input  logic [4:0]  i_current_hours,
    input  logic [5:0]  i_current_minutes,
    input  logic [1:0]  i_relay_select,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_command_found,
    output logic        o_time_write,
    output logic [4:0]  o_new_hours,
    output logic [5:0]  o_new_minutes,
    output logic [5:0]  o_new_seconds,
    output logic [2:0]  o_relay_on_mask,
    output logic [2:0]  o_switch_mode_mask,
    output logic        o_sensor_enable,
    output logic [15:0] o_upper_limit,
    output logic [15:0] o_lower_limit,
    output logic [29:0] o_selected_duration_ms
);

    localparam int MODE_N = (RELAY_COUNT < MODE_MAX) ? RELAY_COUNT : MODE_MAX;

    // Input register.
    logic       r_in_valid;
    logic       r_in_kind;
    logic [7:0] r_in_char;
    logic [4:0] r_in_hours;
    logic [5:0] r_in_minutes;
    logic [1:0] r_in_sel;

    // Settings.
    logic [11:0]            r_on_time  [RELAY_COUNT];
    logic [11:0]            r_off_time [RELAY_COUNT];
    logic [29:0]            r_pulse_ms [RELAY_COUNT];
    logic [RELAY_COUNT-1:0] r_mode;
    logic [15:0]            r_upper;
    logic [15:0]            r_lower;
    logic                   r_sensor;

    logic [11:0]            n_on_time  [RELAY_COUNT];
    logic [11:0]            n_off_time [RELAY_COUNT];
    logic [29:0]            n_pulse_ms [RELAY_COUNT];
    logic [RELAY_COUNT-1:0] n_mode;
    logic [15:0]            n_upper;
    logic [15:0]            n_lower;
    logic                   n_sensor;

    // Result register.
    logic        r_out_valid;
    logic        r_out_found;
    logic        r_out_twrite;
    logic [4:0]  r_out_hours;
    logic [5:0]  r_out_minutes;
    logic [5:0]  r_out_seconds;
    logic [2:0]  r_out_on_mask;
    logic [2:0]  r_out_mode_mask;
    logic        r_out_sensor;
    logic [15:0] r_out_upper;
    logic [15:0] r_out_lower;
    logic [29:0] r_out_dur;

    logic                   out_free;
    logic                   fire;
    logic                   char_fire;
    t_frame_cmd             cmd;
    logic [11:0]            act;
    logic [RELAY_COUNT-1:0] on_vec;
    logic [MAX_RELAYS-1:0]  on_pad;
    logic [MAX_RELAYS-1:0]  mode_pad;
    logic [29:0]            dur;
    logic                   twrite;

    // Handshake: the input register moves whenever the result register can take it.
    assign out_free  = !r_out_valid || !i_stall;
    assign fire      = r_in_valid && out_free;
    assign char_fire = fire && !r_in_kind;
    assign o_stall   = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_kind    <= i_kind;
            r_in_char    <= i_char_byte;
            r_in_hours   <= i_current_hours;
            r_in_minutes <= i_current_minutes;
            r_in_sel     <= i_relay_select;
        end
    end

    // Character window and frame decoder.
    cfrs_frame #(
        .RELAY_COUNT(RELAY_COUNT)
    ) u_frame (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_shift(char_fire),
        .i_char (r_in_char),
        .o_cmd  (cmd)
    );

    // Settings update from a decoded frame.
    always_comb begin
        n_on_time  = r_on_time;
        n_off_time = r_off_time;
        n_pulse_ms = r_pulse_ms;
        n_mode     = r_mode;
        n_upper    = r_upper;
        n_lower    = r_lower;
        n_sensor   = r_sensor;
        twrite     = 1'b0;
        if (char_fire) begin
            unique case (cmd.op)
                OP_CLOCK: begin
                    twrite = 1'b1;
                end
                OP_ON_TIME: begin
                    for (int r = 0; r < RELAY_COUNT; r++) begin
                        if (cmd.all_relays || (int'(cmd.relay) == r)) begin
                            n_on_time[r] = cmd.hhmm;
                        end
                    end
                end
                OP_OFF_TIME: begin
                    for (int r = 0; r < RELAY_COUNT; r++) begin
                        if (cmd.all_relays || (int'(cmd.relay) == r)) begin
                            n_off_time[r] = cmd.hhmm;
                        end
                    end
                end
                OP_PULSE: begin
                    for (int r = 0; r < RELAY_COUNT; r++) begin
                        if (int'(cmd.relay) == r) begin
                            n_pulse_ms[r] = cmd.ms;
                        end
                    end
                end
                OP_MODE: begin
                    for (int r = 0; r < RELAY_COUNT; r++) begin
                        if (r < MODE_N) begin
                            n_mode[r] = cmd.mode_bits[r];
                        end
                    end
                end
                OP_UPPER: begin
                    n_upper = cmd.limit;
                end
                OP_LOWER: begin
                    n_lower = cmd.limit;
                end
                OP_SENSOR: begin
                    n_sensor = cmd.sensor_on;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < RELAY_COUNT; r++) begin
                r_on_time[r]  <= RST_ON_TIME;
                r_off_time[r] <= RST_OFF_TIME;
                r_pulse_ms[r] <= RST_PULSE_MS;
            end
            r_mode   <= '0;
            r_upper  <= RST_UPPER;
            r_lower  <= RST_LOWER;
            r_sensor <= 1'b0;
        end else begin
            r_on_time  <= n_on_time;
            r_off_time <= n_off_time;
            r_pulse_ms <= n_pulse_ms;
            r_mode     <= n_mode;
            r_upper    <= n_upper;
            r_lower    <= n_lower;
            r_sensor   <= n_sensor;
        end
    end

    // Schedule query: each relay's on window, wrapping past midnight when on > off.
    always_comb begin
        act = 12'(r_in_hours) * 12'd100 + 12'(r_in_minutes);
        for (int r = 0; r < RELAY_COUNT; r++) begin
            if (r_on_time[r] < r_off_time[r]) begin
                on_vec[r] = (act >= r_on_time[r]) && (act < r_off_time[r]);
            end else if (r_on_time[r] > r_off_time[r]) begin
                on_vec[r] = (act >= r_on_time[r]) || (act < r_off_time[r]);
            end else begin
                on_vec[r] = 1'b0;
            end
        end
        on_pad   = r_in_kind ? MAX_RELAYS'(on_vec) : '0;
        mode_pad = MAX_RELAYS'(n_mode);
    end

    // Pulse length of the selected relay, zero when the relay does not exist.
    always_comb begin
        dur = '0;
        for (int r = 0; r < RELAY_COUNT; r++) begin
            if (int'(r_in_sel) == r) begin
                dur = n_pulse_ms[r];
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_found     <= !r_in_kind && cmd.found;
            r_out_twrite    <= twrite;
            r_out_hours     <= twrite ? cmd.hours : 5'd0;
            r_out_minutes   <= twrite ? cmd.minutes : 6'd0;
            r_out_seconds   <= twrite ? cmd.seconds : 6'd0;
            r_out_on_mask   <= on_pad[MASK_W-1:0];
            r_out_mode_mask <= mode_pad[MASK_W-1:0];
            r_out_sensor    <= n_sensor;
            r_out_upper     <= n_upper;
            r_out_lower     <= n_lower;
            r_out_dur       <= dur;
        end
    end

    assign o_valid                = r_out_valid;
    assign o_command_found        = r_out_found;
    assign o_time_write           = r_out_twrite;
    assign o_new_hours            = r_out_hours;
    assign o_new_minutes          = r_out_minutes;
    assign o_new_seconds          = r_out_seconds;
    assign o_relay_on_mask        = r_out_on_mask;
    assign o_switch_mode_mask     = r_out_mode_mask;
    assign o_sensor_enable        = r_out_sensor;
    assign o_upper_limit          = r_out_upper;
    assign o_lower_limit          = r_out_lower;
    assign o_selected_duration_ms = r_out_dur;

    // Checks on the block's own logic.
`include "command_frame_parser_relay_schedule_unit_macros.svh"

    `CFRS_ASSERT_IMPL(a_twrite_found, o_valid && o_time_write, o_command_found,
        "clock write without a found command")
    `CFRS_ASSERT_IMPL(a_new_time_zero, o_valid && !o_time_write,
        (o_new_hours == 5'd0) && (o_new_minutes == 6'd0) && (o_new_seconds == 6'd0),
        "clock fields set without a clock write")
    `CFRS_ASSERT_IMPL(a_query_vs_frame, o_valid && (o_relay_on_mask != 3'd0),
        !o_command_found, "schedule mask and found command in one result")
    `CFRS_ASSERT_NEXT(a_accept_loads, i_valid && !o_stall, r_in_valid,
        "accepted item did not reach the input register")

endmodule

[src/cfrs_frame.sv]
// Character window and frame decoder for the relay schedule unit.
// Depends on cfrs_pkg for character codes and the decoded command struct.
`timescale 1ns / 1ps

module cfrs_frame import cfrs_pkg::*; #(
    parameter int RELAY_COUNT = 3
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  logic [7:0] i_char,
    output t_frame_cmd o_cmd
);

    localparam int MODE_N = (RELAY_COUNT < MODE_MAX) ? RELAY_COUNT : MODE_MAX;

    // Decimal weights of the pulse length, already scaled to milliseconds.
    localparam logic [29:0] MS_W [6] = '{30'd100000000, 30'd10000000, 30'd1000000,
                                        30'd100000, 30'd10000, 30'd1000};
    // Limit weights reduced modulo 65536.
    localparam logic [15:0] LIM_W [6] = '{16'd34464, 16'd10000, 16'd1000,
                                         16'd100, 16'd10, 16'd1};

    // r_hist[0] is the previous character, r_hist[HIST_LEN-1] the oldest.
    logic [7:0] r_hist [HIST_LEN];

    logic [7:0]  p     [6];
    logic [4:0]  hex_d [6];
    logic        frame_hit;
    logic        all_hex;
    logic        all_dec;
    logic        any_nonzero;
    logic        hhmm_dec;
    logic [6:0]  hh;
    logic [6:0]  mm;
    logic        hhmm_ok;
    logic [7:0]  clk_h;
    logic [7:0]  clk_m;
    logic [7:0]  clk_s;
    logic        clock_ok;
    logic [29:0] ms_sum;
    logic [15:0] lim_sum;
    logic        mode_ok;
    logic [MAX_RELAYS-1:0] mode_bits;
    logic        sensor_ok;
    logic        sensor_any;

    // Shift the window by one character per character item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_LEN; i++) begin
                r_hist[i] <= CH_ZERO;
            end
        end else if (i_shift) begin
            r_hist[0] <= i_char;
            for (int i = 1; i < HIST_LEN; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    // Parameter digits and their checks, all in parallel.
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            p[i]     = r_hist[6-i];
            hex_d[i] = hex_val(p[i]);
        end

        all_hex     = 1'b1;
        all_dec     = 1'b1;
        any_nonzero = 1'b0;
        ms_sum      = '0;
        lim_sum     = '0;
        for (int i = 0; i < 6; i++) begin
            all_hex     = all_hex & ~hex_d[i][4];
            all_dec     = all_dec & is_dec(p[i]);
            any_nonzero = any_nonzero | (p[i][3:0] != 4'd0);
            ms_sum      = ms_sum + 30'(p[i][3:0]) * MS_W[i];
            lim_sum     = lim_sum + 16'(hex_d[i][3:0]) * LIM_W[i];
        end

        // HHMM in decimal from the first four parameters.
        hhmm_dec = is_dec(p[0]) & is_dec(p[1]) & is_dec(p[2]) & is_dec(p[3]);
        hh       = 7'(p[0][3:0]) * 7'd10 + 7'(p[1][3:0]);
        mm       = 7'(p[2][3:0]) * 7'd10 + 7'(p[3][3:0]);
        hhmm_ok  = hhmm_dec && (hh <= 7'd23) && (mm <= 7'd59);

        // Clock write digits are hex decoded and then range checked.
        clk_h    = 8'(hex_d[0][3:0]) * 8'd10 + 8'(hex_d[1][3:0]);
        clk_m    = 8'(hex_d[2][3:0]) * 8'd10 + 8'(hex_d[3][3:0]);
        clk_s    = 8'(hex_d[4][3:0]) * 8'd10 + 8'(hex_d[5][3:0]);
        clock_ok = all_hex && (clk_h <= 8'd23) && (clk_m <= 8'd59) && (clk_s <= 8'd59);

        // Mode digits must be binary for every covered relay.
        mode_ok   = 1'b1;
        mode_bits = '0;
        for (int i = 0; i < MODE_MAX; i++) begin
            if (i < MODE_N) begin
                mode_ok      = mode_ok & ((p[i] == CH_ZERO) || (p[i] == CH_ONE));
                mode_bits[i] = (p[i] == CH_ONE);
            end
        end

        // Sensor enable looks at the middle four digits.
        sensor_ok  = 1'b1;
        sensor_any = 1'b0;
        for (int i = 1; i < 5; i++) begin
            sensor_ok  = sensor_ok & ~hex_d[i][4];
            sensor_any = sensor_any | (hex_d[i][3:0] != 4'd0);
        end
    end

    // Frame detection and command dispatch.
    always_comb begin
        frame_hit = (r_hist[8] == CH_X) && (r_hist[0] == CH_DOLLAR) && (i_char == CH_NL);

        o_cmd            = '0;
        o_cmd.op         = OP_NONE;
        o_cmd.hhmm       = 12'(hh) * 12'd100 + 12'(mm);
        o_cmd.ms         = ms_sum;
        o_cmd.mode_bits  = mode_bits;
        o_cmd.limit      = lim_sum;
        o_cmd.sensor_on  = sensor_any;

        if (frame_hit) begin
            o_cmd.found = 1'b1;
            unique case (r_hist[7])
                CMD_T: begin
                    if (clock_ok) begin
                        o_cmd.op      = OP_CLOCK;
                        o_cmd.hours   = clk_h[4:0];
                        o_cmd.minutes = clk_m[5:0];
                        o_cmd.seconds = clk_s[5:0];
                    end
                end
                CMD_I: begin
                    o_cmd.op = OP_NONE;
                end
                CMD_N, CMD_B, CMD_C, CMD_D: begin
                    if (hhmm_ok) begin
                        o_cmd.op = OP_ON_TIME;
                    end
                    o_cmd.all_relays = (r_hist[7] == CMD_N);
                    o_cmd.relay      = (r_hist[7] == CMD_C) ? 2'd1 :
                                       (r_hist[7] == CMD_D) ? 2'd2 : 2'd0;
                end
                CMD_F, CMD_E, CMD_G, CMD_H: begin
                    if (hhmm_ok) begin
                        o_cmd.op = OP_OFF_TIME;
                    end
                    o_cmd.all_relays = (r_hist[7] == CMD_F);
                    o_cmd.relay      = (r_hist[7] == CMD_G) ? 2'd1 :
                                       (r_hist[7] == CMD_H) ? 2'd2 : 2'd0;
                end
                CMD_J, CMD_K, CMD_L: begin
                    if (all_dec && any_nonzero) begin
                        o_cmd.op = OP_PULSE;
                    end
                    o_cmd.relay = (r_hist[7] == CMD_K) ? 2'd1 :
                                  (r_hist[7] == CMD_L) ? 2'd2 : 2'd0;
                end
                CMD_M: begin
                    if (mode_ok) begin
                        o_cmd.op = OP_MODE;
                    end
                end
                CMD_O: begin
                    if (all_hex) begin
                        o_cmd.op = OP_UPPER;
                    end
                end
                CMD_U: begin
                    if (all_hex) begin
                        o_cmd.op = OP_LOWER;
                    end
                end
                CMD_A: begin
                    if (sensor_ok) begin
                        o_cmd.op = OP_SENSOR;
                    end
                end
                default: begin
                    o_cmd.found = 1'b0;
                end
            endcase
        end
    end

endmodule

[verif/command_frame_parser_relay_schedule_unit_tb.sv]
// Self-checking testbench for the command frame parser and relay schedule unit.
// Depends on cfrs_pkg, the unit's top level, cfrs_frame and the macro header; needs no argument.
`timescale 1ns / 1ps

module command_frame_parser_relay_schedule_unit_tb;
    import cfrs_pkg::*;

    localparam int RELAYS      = 3;
    localparam int HOLD_CYCLES = 200;
    localparam int RANDOM_ITEMS = 800;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 8;

    localparam bit KIND_CHAR  = 1'b0;
    localparam bit KIND_QUERY = 1'b1;

    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LC_A    = 8'h61;
    localparam logic [7:0] CH_LC_F    = 8'h66;
    localparam logic [7:0] CH_UNKNOWN = 8'h5A;

    // One input item as the block takes it.
    typedef struct packed {
        logic       kind;
        logic [7:0] char_byte;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [1:0] relay_sel;
    } rx_item_t;

    // One status result as the block returns it.
    typedef struct packed {
        logic        command_found;
        logic        time_write;
        logic [4:0]  new_hours;
        logic [5:0]  new_minutes;
        logic [5:0]  new_seconds;
        logic [2:0]  relay_on_mask;
        logic [2:0]  switch_mode_mask;
        logic        sensor_enable;
        logic [15:0] upper_limit;
        logic [15:0] lower_limit;
        logic [29:0] duration_ms;
    } status_t;

    // Tracks the frame window and relay settings, and checks each status result.
    class relay_status_scoreboard;
        logic [7:0]  win [WINDOW_LEN];
        logic [7:0]  prm [6];
        int          on_hh [RELAYS];
        int          on_mm [RELAYS];
        int          off_hh [RELAYS];
        int          off_mm [RELAYS];
        bit          mode_bit [RELAYS];
        int unsigned pulse_len [RELAYS];
        logic [15:0] upper_lim;
        logic [15:0] lower_lim;
        bit          sensor_on;
        status_t     status_due [$];
        int          error_count;
        int          result_count;

        function new();
            for (int i = 0; i < WINDOW_LEN; i++) win[i] = CH_ZERO;
            for (int i = 0; i < RELAYS; i++) begin
                on_hh[i]     = int'(RST_ON_TIME) / 100;
                on_mm[i]     = int'(RST_ON_TIME) % 100;
                off_hh[i]    = int'(RST_OFF_TIME) / 100;
                off_mm[i]    = int'(RST_OFF_TIME) % 100;
                mode_bit[i]  = 1'b0;
                pulse_len[i] = 32'(RST_PULSE_MS);
            end
            upper_lim   = RST_UPPER;
            lower_lim   = RST_LOWER;
            sensor_on   = 1'b0;
            error_count = 0;
            result_count = 0;
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        // Hex digit value, 16 for anything that is not a hex digit.
        function int hex_nibble(logic [7:0] c);
            if (c >= CH_ZERO && c <= CH_NINE) return int'(c) - int'(CH_ZERO);
            if (c >= CMD_A && c <= CMD_F) return int'(c) - int'(CMD_A) + 10;
            if (c >= CH_LC_A && c <= CH_LC_F) return int'(c) - int'(CH_LC_A) + 10;
            return 16;
        endfunction

        // HHMM from the first four parameters, decimal only.
        function bit read_hhmm(output int hh, output int mm);
            for (int i = 0; i < 4; i++)
                if (!is_digit(prm[i])) return 1'b0;
            hh = hex_nibble(prm[0]) * 10 + hex_nibble(prm[1]);
            mm = hex_nibble(prm[2]) * 10 + hex_nibble(prm[3]);
            return hh <= 23 && mm <= 59;
        endfunction

        function void apply_time(int rl, bit set_on);
            int hh, mm;
            if (rl >= RELAYS || !read_hhmm(hh, mm)) return;
            if (set_on) begin
                on_hh[rl] = hh;
                on_mm[rl] = mm;
            end else begin
                off_hh[rl] = hh;
                off_mm[rl] = mm;
            end
        endfunction

        // Pulse length is six decimal seconds, nonzero, kept in ms.
        function void apply_pulse(int rl);
            int unsigned secs;
            secs = 0;
            if (rl >= RELAYS) return;
            for (int i = 0; i < 6; i++) begin
                if (!is_digit(prm[i])) return;
                secs = secs * 10 + 32'(hex_nibble(prm[i]));
            end
            if (secs == 0) return;
            pulse_len[rl] = secs * 1000;
        endfunction

        function void apply_mode();
            int n;
            n = (RELAYS < MODE_MAX) ? RELAYS : MODE_MAX;
            for (int r = 0; r < n; r++)
                if (prm[r] != CH_ZERO && prm[r] != CH_ONE) return;
            for (int r = 0; r < n; r++) mode_bit[r] = (prm[r] == CH_ONE);
        endfunction

        // Hex digits weighted by decimal powers, wrapped to 16 bits.
        function bit read_limit(output logic [15:0] v);
            int unsigned w [6] = '{100000, 10000, 1000, 100, 10, 1};
            int unsigned acc;
            int d;
            acc = 0;
            for (int i = 0; i < 6; i++) begin
                d = hex_nibble(prm[i]);
                if (d > 15) return 1'b0;
                acc += 32'(d) * w[i];
            end
            v = acc[15:0];
            return 1'b1;
        endfunction

        function bit read_clock(output int hh, output int mm, output int ss);
            int d [6];
            for (int i = 0; i < 6; i++) begin
                d[i] = hex_nibble(prm[i]);
                if (d[i] > 15) return 1'b0;
            end
            hh = d[0] * 10 + d[1];
            mm = d[2] * 10 + d[3];
            ss = d[4] * 10 + d[5];
            return hh <= 23 && mm <= 59 && ss <= 59;
        endfunction

        // Equal times mean off; on later than off wraps past midnight.
        function bit relay_lit(int rl, int act);
            int t_on, t_off;
            t_on  = on_hh[rl] * 100 + on_mm[rl];
            t_off = off_hh[rl] * 100 + off_mm[rl];
            if (t_on < t_off) return act >= t_on && act < t_off;
            if (t_on > t_off) return act >= t_on || act < t_off;
            return 1'b0;
        endfunction

        // Update the settings for an accepted item and queue the status it gives.
        function void note_item(rx_item_t it);
            status_t st;
            int hh, mm, ss, act, d, any_bits;
            bit ok;
            logic [15:0] lim;
            st = '0;
            if (it.kind == KIND_CHAR) begin
                for (int i = WINDOW_LEN - 1; i > 0; i--) win[i] = win[i - 1];
                win[0] = it.char_byte;
                if (win[9] == CH_X && win[1] == CH_DOLLAR && win[0] == CH_NL) begin
                    for (int i = 0; i < 6; i++) prm[i] = win[7 - i];
                    st.command_found = 1'b1;
                    case (win[8])
                        CMD_T: begin
                            if (read_clock(hh, mm, ss)) begin
                                st.time_write  = 1'b1;
                                st.new_hours   = 5'(hh);
                                st.new_minutes = 6'(mm);
                                st.new_seconds = 6'(ss);
                            end
                        end
                        CMD_I: ;
                        CMD_N: for (int r = 0; r < RELAYS; r++) apply_time(r, 1'b1);
                        CMD_F: for (int r = 0; r < RELAYS; r++) apply_time(r, 1'b0);
                        CMD_B: apply_time(0, 1'b1);
                        CMD_C: apply_time(1, 1'b1);
                        CMD_D: apply_time(2, 1'b1);
                        CMD_E: apply_time(0, 1'b0);
                        CMD_G: apply_time(1, 1'b0);
                        CMD_H: apply_time(2, 1'b0);
                        CMD_J: apply_pulse(0);
                        CMD_K: apply_pulse(1);
                        CMD_L: apply_pulse(2);
                        CMD_M: apply_mode();
                        CMD_O: if (read_limit(lim)) upper_lim = lim;
                        CMD_U: if (read_limit(lim)) lower_lim = lim;
                        CMD_A: begin
                            ok = 1'b1;
                            any_bits = 0;
                            for (int i = 1; i < 5; i++) begin
                                d = hex_nibble(prm[i]);
                                if (d > 15) ok = 1'b0;
                                else any_bits |= d;
                            end
                            if (ok) sensor_on = (any_bits != 0);
                        end
                        default: st.command_found = 1'b0;
                    endcase
                end
            end else begin
                act = int'(it.hours) * 100 + int'(it.minutes);
                for (int r = 0; r < RELAYS && r < 3; r++)
                    st.relay_on_mask[r] = relay_lit(r, act);
            end
            for (int r = 0; r < RELAYS && r < 3; r++) st.switch_mode_mask[r] = mode_bit[r];
            st.sensor_enable = sensor_on;
            st.upper_limit   = upper_lim;
            st.lower_limit   = lower_lim;
            st.duration_ms   = (int'(it.relay_sel) < RELAYS) ?
                               30'(pulse_len[it.relay_sel]) : 30'd0;
            status_due.push_back(st);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t: mismatch in %s of result %0d: got %0d, expected %0d",
                     $time, what, result_count, got, want);
            error_count++;
        endtask

        // Compare a returned status with the oldest one still due.
        task check_status(status_t got);
            status_t want;
            if (status_due.size() == 0) begin
                report("result with nothing expected", 0, 0);
                return;
            end
            want = status_due.pop_front();
            if (got.command_found !== want.command_found)
                report("command_found", got.command_found, want.command_found);
            if (got.time_write !== want.time_write)
                report("time_write", got.time_write, want.time_write);
            if (got.new_hours !== want.new_hours)
                report("new_hours", got.new_hours, want.new_hours);
            if (got.new_minutes !== want.new_minutes)
                report("new_minutes", got.new_minutes, want.new_minutes);
            if (got.new_seconds !== want.new_seconds)
                report("new_seconds", got.new_seconds, want.new_seconds);
            if (got.relay_on_mask !== want.relay_on_mask)
                report("relay_on_mask", got.relay_on_mask, want.relay_on_mask);
            if (got.switch_mode_mask !== want.switch_mode_mask)
                report("switch_mode_mask", got.switch_mode_mask, want.switch_mode_mask);
            if (got.sensor_enable !== want.sensor_enable)
                report("sensor_enable", got.sensor_enable, want.sensor_enable);
            if (got.upper_limit !== want.upper_limit)
                report("upper_limit", got.upper_limit, want.upper_limit);
            if (got.lower_limit !== want.lower_limit)
                report("lower_limit", got.lower_limit, want.lower_limit);
            if (got.duration_ms !== want.duration_ms)
                report("selected_duration_ms", got.duration_ms, want.duration_ms);
            result_count++;
        endtask

        function int outstanding();
            return status_due.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_kind = 1'b0;
    logic [7:0]  i_char_byte = 8'h00;
    logic [4:0]  i_current_hours = 5'd0;
    logic [5:0]  i_current_minutes = 6'd0;
    logic [1:0]  i_relay_select = 2'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_command_found;
    logic        o_time_write;
    logic [4:0]  o_new_hours;
    logic [5:0]  o_new_minutes;
    logic [5:0]  o_new_seconds;
    logic [2:0]  o_relay_on_mask;
    logic [2:0]  o_switch_mode_mask;
    logic        o_sensor_enable;
    logic [15:0] o_upper_limit;
    logic [15:0] o_lower_limit;
    logic [29:0] o_selected_duration_ms;

    relay_status_scoreboard sb;
    int items_sent = 0;
    int fast_left = 0;
    int cycle_count = 0;
    bit hold_request = 1'b0;
    bit hold_done = 1'b0;

    logic [7:0] cmd_table [17] = '{CMD_T, CMD_I, CMD_N, CMD_F, CMD_B, CMD_C, CMD_D, CMD_E,
                                   CMD_G, CMD_H, CMD_J, CMD_K, CMD_L, CMD_M, CMD_O, CMD_U,
                                   CMD_A};

    command_frame_parser_relay_schedule_unit #(
        .RELAY_COUNT(RELAYS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_kind(i_kind),
        .i_char_byte(i_char_byte),
        .i_current_hours(i_current_hours),
        .i_current_minutes(i_current_minutes),
        .i_relay_select(i_relay_select),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_command_found(o_command_found),
        .o_time_write(o_time_write),
        .o_new_hours(o_new_hours),
        .o_new_minutes(o_new_minutes),
        .o_new_seconds(o_new_seconds),
        .o_relay_on_mask(o_relay_on_mask),
        .o_switch_mode_mask(o_switch_mode_mask),
        .o_sensor_enable(o_sensor_enable),
        .o_upper_limit(o_upper_limit),
        .o_lower_limit(o_lower_limit),
        .o_selected_duration_ms(o_selected_duration_ms)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [7:0] dec_char(int v);
        return 8'(int'(CH_ZERO) + v);
    endfunction

    function automatic logic [7:0] hex_char(int v);
        if (v < 10) return 8'(int'(CH_ZERO) + v);
        return 8'(int'($urandom_range(0, 1) ? CH_LC_A : CMD_A) + (v - 10));
    endfunction

    function automatic rx_item_t char_item(logic [7:0] c);
        rx_item_t it;
        it.kind      = KIND_CHAR;
        it.char_byte = c;
        it.hours     = 5'($urandom);
        it.minutes   = 6'($urandom);
        it.relay_sel = 2'($urandom_range(0, 3));
        return it;
    endfunction

    // Offer one item, hold it until accepted, then note it.
    task automatic put_item(rx_item_t it);
        int gap;
        if ((hold_request && !hold_done) || fast_left > 0) begin
            gap = 0;
            if (fast_left > 0) fast_left--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 49) == 0) fast_left = $urandom_range(30, 80);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_kind            <= it.kind;
        i_char_byte       <= it.char_byte;
        i_current_hours   <= it.hours;
        i_current_minutes <= it.minutes;
        i_relay_select    <= it.relay_sel;
        do @(posedge i_clk); while (o_stall);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic send_query(int hh, int mm, int sel);
        rx_item_t it;
        it.kind      = KIND_QUERY;
        it.char_byte = 8'($urandom);
        it.hours     = 5'(hh);
        it.minutes   = 6'(mm);
        it.relay_sel = 2'(sel);
        put_item(it);
    endtask

    // A whole frame; broken_pos >= 0 replaces that character with a random byte.
    task automatic send_frame(logic [7:0] cmd, logic [47:0] params, int broken_pos);
        logic [7:0] seq [10];
        seq[0] = CH_X;
        seq[1] = cmd;
        for (int i = 0; i < 6; i++) seq[2 + i] = params[47 - 8 * i -: 8];
        seq[8] = CH_DOLLAR;
        seq[9] = CH_NL;
        if (broken_pos >= 0) seq[broken_pos] = 8'($urandom_range(0, 255));
        for (int i = 0; i < 10; i++) put_item(char_item(seq[i]));
    endtask

    // Parameters shaped to the command so that most frames get past the checks.
    function automatic logic [47:0] random_params(logic [7:0] cmd);
        logic [7:0] p [6];
        int hh, mm, ss;
        for (int i = 0; i < 6; i++) p[i] = dec_char($urandom_range(0, 9));
        case (cmd)
            CMD_N, CMD_F, CMD_B, CMD_C, CMD_D, CMD_E, CMD_G, CMD_H: begin
                hh = $urandom_range(0, 25);
                mm = $urandom_range(0, 61);
                p[0] = dec_char(hh / 10);
                p[1] = dec_char(hh % 10);
                p[2] = dec_char(mm / 10);
                p[3] = dec_char(mm % 10);
            end
            CMD_T: begin
                if ($urandom_range(0, 3) != 0) begin
                    hh = $urandom_range(0, 25);
                    mm = $urandom_range(0, 61);
                    ss = $urandom_range(0, 61);
                    p[0] = dec_char(hh / 10);
                    p[1] = dec_char(hh % 10);
                    p[2] = dec_char(mm / 10);
                    p[3] = dec_char(mm % 10);
                    p[4] = dec_char(ss / 10);
                    p[5] = dec_char(ss % 10);
                end else begin
                    for (int i = 0; i < 6; i++) p[i] = hex_char($urandom_range(0, 15));
                end
            end
            CMD_J, CMD_K, CMD_L: begin
                if ($urandom_range(0, 9) == 0)
                    for (int i = 0; i < 6; i++) p[i] = CH_ZERO;
            end
            CMD_M: begin
                for (int i = 0; i < 6; i++)
                    if ($urandom_range(0, 9) != 0) p[i] = dec_char($urandom_range(0, 1));
            end
            CMD_O, CMD_U, CMD_A: begin
                for (int i = 0; i < 6; i++) p[i] = hex_char($urandom_range(0, 15));
                if (cmd == CMD_A && $urandom_range(0, 4) < 2)
                    for (int i = 1; i < 5; i++) p[i] = CH_ZERO;
            end
            default: begin
                for (int i = 0; i < 6; i++) p[i] = 8'($urandom_range(0, 255));
            end
        endcase
        // Occasionally a stray byte among the parameters.
        if ($urandom_range(0, 9) == 0) p[$urandom_range(0, 5)] = 8'($urandom_range(0, 255));
        return {p[0], p[1], p[2], p[3], p[4], p[5]};
    endfunction

    // Stop offering and wait until every due status has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    // Result side: sample every accepted status.
    always @(posedge i_clk) begin
        status_t got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.command_found    = o_command_found;
            got.time_write       = o_time_write;
            got.new_hours        = o_new_hours;
            got.new_minutes      = o_new_minutes;
            got.new_seconds      = o_new_seconds;
            got.relay_on_mask    = o_relay_on_mask;
            got.switch_mode_mask = o_switch_mode_mask;
            got.sensor_enable    = o_sensor_enable;
            got.upper_limit      = o_upper_limit;
            got.lower_limit      = o_lower_limit;
            got.duration_ms      = o_selected_duration_ms;
            sb.check_status(got);
        end
    end

    // Receiver stalls: random runs, quiet stretches, and one long hold on request.
    initial begin
        int r;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request && !hold_done) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    i_stall <= 1'b0;
                    repeat ($urandom_range(40, 120)) @(posedge i_clk);
                end else if (r < 55) begin
                    i_stall <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end else begin
                    i_stall <= 1'b1;
                    repeat (pick_gap() + 1) @(posedge i_clk);
                end
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Reset, directed frames and queries, then random traffic.
    initial begin
        int base, r;
        bit hold_started, drain_started;
        logic [7:0] cmd;
        sb = new();
        hold_started  = 1'b0;
        drain_started = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset schedule wraps midnight; boundaries and out-of-range clock values.
        send_query(0, 0, 0);
        send_query(23, 59, 3);
        send_query(22, 10, 1);
        send_query(5, 1, 2);
        send_query(31, 63, 0);
        put_item(char_item(8'h00));
        put_item(char_item(8'hFF));

        // Clock writes: extremes, hex digits, out of range and a non-hex digit.
        send_frame(CMD_T, "235959", -1);
        send_frame(CMD_T, "000000", -1);
        send_frame(CMD_T, "1F0000", -1);
        send_frame(CMD_T, "0a0B0c", -1);
        send_frame(CMD_T, "12z000", -1);
        send_frame(CMD_I, "abcdef", -1);

        // Per-relay times, rejected hours and minutes, a wrapping window.
        send_frame(CMD_B, "0600xx", -1);
        send_frame(CMD_E, "180099", -1);
        send_frame(CMD_C, "240000", -1);
        send_frame(CMD_G, "006000", -1);
        send_frame(CMD_D, "200000", -1);
        send_frame(CMD_H, "040000", -1);
        send_query(3, 0, 2);
        send_query(19, 0, 0);

        // Equal on and off times switch every relay off.
        send_frame(CMD_N, "235900", -1);
        send_frame(CMD_F, "235900", -1);
        send_query(12, 0, 1);

        // Pulse lengths: largest, zero, non-decimal, smallest.
        send_frame(CMD_J, "999999", -1);
        send_frame(CMD_K, "000000", -1);
        send_frame(CMD_L, "00001a", -1);
        send_frame(CMD_L, "000001", -1);
        send_frame(CMD_M, "101000", -1);
        send_frame(CMD_M, "120000", -1);

        // Limits wrap to 16 bits; a non-hex digit rejects.
        send_frame(CMD_O, "FFFFFF", -1);
        send_frame(CMD_U, "000000", -1);
        send_frame(CMD_O, "12g456", -1);
        send_frame(CMD_U, "fffabc", -1);

        // Sensor enable looks only at the middle four digits.
        send_frame(CMD_A, "0F0000", -1);
        send_frame(CMD_A, "X0000X", -1);
        send_frame(CMD_A, "1000z0", -1);
        send_frame(CH_UNKNOWN, "123456", -1);

        // Random part: mostly well-formed frames, with queries, noise and broken frames.
        base = items_sent;
        while (items_sent < base + RANDOM_ITEMS) begin
            if (!hold_started && items_sent >= base + 300) begin
                hold_request = 1'b1;
                hold_started = 1'b1;
            end
            if (!drain_started && items_sent >= base + 700) begin
                drain_results();
                drain_started = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 62) begin
                cmd = cmd_table[$urandom_range(0, 16)];
                send_frame(cmd, random_params(cmd),
                           ($urandom_range(0, 11) == 0) ? int'($urandom_range(0, 9)) : -1);
            end else if (r < 84) begin
                repeat ($urandom_range(1, 3))
                    send_query(($urandom_range(0, 9) == 0) ? $urandom_range(24, 31)
                                                           : $urandom_range(0, 23),
                               ($urandom_range(0, 9) == 0) ? $urandom_range(60, 63)
                                                           : $urandom_range(0, 59),
                               $urandom_range(0, 3));
            end else if (r < 95) begin
                repeat ($urandom_range(1, 4)) put_item(char_item(8'($urandom_range(0, 255))));
            end else begin
                cmd = 8'($urandom_range(0, 255));
                send_frame(cmd, random_params(cmd), -1);
            end
        end

        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.error_count == 0 && sb.outstanding() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/cfrs_pkg.sv
src/cfrs_frame.sv
src/command_frame_parser_relay_schedule_unit.sv
verif/command_frame_parser_relay_schedule_unit_tb.sv
